FILE: src/nhr_pkg.sv
// Shared types, codes and one's-complement helpers for the NAT header rewrite unit.
package nhr_pkg;

  localparam int unsigned NHR_STAGES = 4;

  localparam logic       MODE_SRC  = 1'b0;
  localparam logic [1:0] PROTO_TCP = 2'd0;
  localparam logic [1:0] PROTO_UDP = 2'd1;

  typedef struct packed {
    logic        mode;
    logic [1:0]  protocol;
    logic [7:0]  hop_count;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] header_sum;
    logic [15:0] transport_sum;
    logic [31:0] mapped_address;
    logic [15:0] mapped_port;
  } nhr_in_t;

  typedef struct packed {
    logic        hop_drop;
    logic [7:0]  hop_count_out;
    logic [31:0] source_address_out;
    logic [31:0] dest_address_out;
    logic [15:0] source_port_out;
    logic [15:0] dest_port_out;
    logic [15:0] header_sum_out;
    logic [15:0] transport_sum_out;
  } nhr_out_t;

  typedef struct packed {
    logic [NHR_STAGES-1:0] load;
    logic [NHR_STAGES-1:0] valid;
  } nhr_ctrl_t;

  // one's-complement contribution of a 16-bit word changing from old_w to new_w
  function automatic logic [15:0] word_delta(input logic [15:0] old_w,
                                             input logic [15:0] new_w);
    logic [16:0] s;
    s = {1'b0, ~old_w} + {1'b0, new_w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // fold an 18-bit sum to 16 bits with end-around carry
  function automatic logic [15:0] fold18(input logic [17:0] x);
    logic [16:0] y;
    y = {1'b0, x[15:0]} + {15'd0, x[17:16]};
    return y[15:0] + {15'd0, y[16]};
  endfunction

endpackage

FILE: src/nhr_stage_ctrl.sv
// Valid and load-enable control for the rewrite pipeline.
module nhr_stage_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_stall,
  output logic               in_stall,
  output nhr_pkg::nhr_ctrl_t ctrl
);
  import nhr_pkg::*;

  logic [NHR_STAGES-1:0] valid_r;
  logic [NHR_STAGES-1:0] valid_nxt;
  logic [NHR_STAGES-1:0] load;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    load[NHR_STAGES-1] = !valid_r[NHR_STAGES-1] || !out_stall;
    for (int i = NHR_STAGES - 2; i >= 0; i--) begin
      load[i] = !valid_r[i] || load[i+1];
    end
  end

  always_comb begin
    valid_nxt[0] = load[0] ? in_valid : valid_r[0];
    for (int i = 1; i < NHR_STAGES; i++) begin
      valid_nxt[i] = load[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall   = !load[0];
  assign ctrl.load  = load;
  assign ctrl.valid = valid_r;

endmodule

FILE: src/nat_header_rewrite_unit.sv
// NAT header rewrite unit: address/port translation with incremental checksum patching.
//
// Takes one request per cycle unless stalled: an IPv4 header tuple plus translated address and port.
// Source mode replaces the source address and port, destination mode the destination ones;
// the TTL is decremented and the IP header checksum patched by one's-complement incremental
// update (HC' = ~(~HC + ~m + m')). For TCP and UDP the layer-4 checksum is patched for the
// pseudo-header address change and the port change; other protocol codes keep ports and
// layer-4 checksum as they are. A TTL of 0 or 1 passes the header unchanged with hop_drop
// set. Throughput is one request per clock while out_stall is low. A request passes the four
// register stages of the checksum datapath (word deltas, three-term sums, add of the old
// checksum, fold and complement) before it shows on out_data. A stalled output holds
// the pipeline without losing or repeating a request; empty stages fill while the output
// is stalled.
module nat_header_rewrite_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  nhr_pkg::nhr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output nhr_pkg::nhr_out_t out_data
);
  import nhr_pkg::*;

  nhr_ctrl_t ctrl;

  nhr_stage_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .ctrl      (ctrl)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: field selection and the four word deltas.
  // The carried result already holds the final addresses, ports and TTL; the sum
  // fields carry the incoming checksums until the last stage patches them.
  // ---------------------------------------------------------------------------
  nhr_out_t    res1_r, res1_nxt;
  logic        l4_1_r, l4_1_nxt;
  logic [15:0] wd_ahi_r, wd_ahi_nxt;
  logic [15:0] wd_alo_r, wd_alo_nxt;
  logic [15:0] wd_port_r, wd_port_nxt;
  logic [15:0] wd_ttl_r, wd_ttl_nxt;

  logic [31:0] old_addr;
  logic [15:0] old_port;
  logic [7:0]  ttl_dec;
  logic        drop;

  always_comb begin
    old_addr = (in_data.mode == MODE_SRC) ? in_data.source_address : in_data.dest_address;
    old_port = (in_data.mode == MODE_SRC) ? in_data.source_port : in_data.dest_port;
    ttl_dec  = in_data.hop_count - 8'd1;
    drop     = (in_data.hop_count <= 8'd1);

    wd_ahi_nxt  = word_delta(old_addr[31:16], in_data.mapped_address[31:16]);
    wd_alo_nxt  = word_delta(old_addr[15:0], in_data.mapped_address[15:0]);
    wd_port_nxt = word_delta(old_port, in_data.mapped_port);
    // TTL is the high byte of its header word
    wd_ttl_nxt  = word_delta({in_data.hop_count, 8'h00}, {ttl_dec, 8'h00});

    l4_1_nxt = (in_data.protocol == PROTO_TCP) || (in_data.protocol == PROTO_UDP);

    res1_nxt.hop_drop           = drop;
    res1_nxt.hop_count_out      = in_data.hop_count;
    res1_nxt.source_address_out = in_data.source_address;
    res1_nxt.dest_address_out   = in_data.dest_address;
    res1_nxt.source_port_out    = in_data.source_port;
    res1_nxt.dest_port_out      = in_data.dest_port;
    res1_nxt.header_sum_out     = in_data.header_sum;
    res1_nxt.transport_sum_out  = in_data.transport_sum;

    if (!drop) begin
      res1_nxt.hop_count_out = ttl_dec;
      if (in_data.mode == MODE_SRC) begin
        res1_nxt.source_address_out = in_data.mapped_address;
        if (l4_1_nxt) begin
          res1_nxt.source_port_out = in_data.mapped_port;
        end
      end else begin
        res1_nxt.dest_address_out = in_data.mapped_address;
        if (l4_1_nxt) begin
          res1_nxt.dest_port_out = in_data.mapped_port;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      res1_r    <= res1_nxt;
      l4_1_r    <= l4_1_nxt;
      wd_ahi_r  <= wd_ahi_nxt;
      wd_alo_r  <= wd_alo_nxt;
      wd_port_r <= wd_port_nxt;
      wd_ttl_r  <= wd_ttl_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: three-term delta sums (address halves plus TTL or port word).
  // ---------------------------------------------------------------------------
  nhr_out_t    res2_r;
  logic        l4_2_r;
  logic [17:0] d_h_r, d_h_nxt;
  logic [17:0] d_t_r, d_t_nxt;

  always_comb begin
    d_h_nxt = {2'b00, wd_ttl_r} + {2'b00, wd_ahi_r} + {2'b00, wd_alo_r};
    d_t_nxt = {2'b00, wd_port_r} + {2'b00, wd_ahi_r} + {2'b00, wd_alo_r};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      res2_r <= res1_r;
      l4_2_r <= l4_1_r;
      d_h_r  <= d_h_nxt;
      d_t_r  <= d_t_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: add the complemented incoming checksums.
  // ---------------------------------------------------------------------------
  nhr_out_t    res3_r;
  logic        l4_3_r;
  logic [17:0] x_h_r, x_h_nxt;
  logic [17:0] x_t_r, x_t_nxt;

  always_comb begin
    x_h_nxt = {2'b00, ~res2_r.header_sum_out} + d_h_r;
    x_t_nxt = {2'b00, ~res2_r.transport_sum_out} + d_t_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      res3_r <= res2_r;
      l4_3_r <= l4_2_r;
      x_h_r  <= x_h_nxt;
      x_t_r  <= x_t_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: fold, complement and pick patched or original sums; output register.
  // ---------------------------------------------------------------------------
  nhr_out_t out_r, out_nxt;

  always_comb begin
    out_nxt = res3_r;
    if (!res3_r.hop_drop) begin
      out_nxt.header_sum_out = ~fold18(x_h_r);
      if (l4_3_r) begin
        out_nxt.transport_sum_out = ~fold18(x_t_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = ctrl.valid[NHR_STAGES-1];
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // a forwarded request never carries a TTL that wrapped below zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hop_drop |-> out_data.hop_count_out != 8'hFF)
    else $error("forwarded request has wrapped TTL");

  // a dropped request keeps its original TTL, which is at most one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hop_drop |-> out_data.hop_count_out <= 8'd1)
    else $error("dropped request carries TTL above one");

  // a held output stage keeps its request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output stage lost a request under stall");

  // stage three, when it cannot move on, keeps its request
  assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.valid[2] && !ctrl.load[2] |=> ctrl.valid[2])
    else $error("stage three lost a request while blocked");

  // input is held off only while every stage is occupied
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (ctrl.valid == {NHR_STAGES{1'b1}}) && out_stall)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
